### hdl/owtr_pkg.sv
// Package for the one-wire temperature reader: payload, configuration and phase types.
`default_nettype none

package owtr_pkg;

   // One tick of the bus sequencer as it comes in.
   typedef struct packed {
      logic start_req;
      logic line_level;
   } req_type;

   // What the reader answers for that tick.
   typedef struct packed {
      logic               drive_low;
      logic               busy_res;
      logic               done_res;
      logic signed [15:0] temperature;
      logic               presence_missing;
   } rsp_type;

   // Timing registers as seen by the sequencer.
   typedef struct packed {
      logic [11:0] reset_low_ticks;
      logic [15:0] presence_poll_ticks;
      logic [3:0]  presence_polls;
      logic [15:0] settle_ticks;
      logic [7:0]  write_hold_ticks;
      logic [5:0]  read_sample_ticks;
      logic [7:0]  read_recover_ticks;
   } cfg_type;

   typedef enum logic [2:0] {
      REG_RESET_LOW     = 3'd0,
      REG_PRESENCE_POLL = 3'd1,
      REG_PRESENCE_CNT  = 3'd2,
      REG_SETTLE        = 3'd3,
      REG_WRITE_HOLD    = 3'd4,
      REG_READ_SAMPLE   = 3'd5,
      REG_READ_RECOVER  = 3'd6
   } csr_idx_type;

   localparam int unsigned CSR_ADDR_W = 5;

   localparam logic [11:0] RESET_LOW_DEFAULT     = 12'd480;
   localparam logic [15:0] PRESENCE_POLL_DEFAULT = 16'd1000;
   localparam logic [3:0]  PRESENCE_CNT_DEFAULT  = 4'd5;
   localparam logic [15:0] SETTLE_DEFAULT        = 16'd1000;
   localparam logic [7:0]  WRITE_HOLD_DEFAULT    = 8'd60;
   localparam logic [5:0]  READ_SAMPLE_DEFAULT   = 6'd3;
   localparam logic [7:0]  READ_RECOVER_DEFAULT  = 8'd50;

   localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
   localparam logic [7:0] CMD_CONVERT  = 8'h44;
   localparam logic [7:0] CMD_READ_PAD = 8'hBE;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_RST1  = 4'd1,
      PH_PRES1 = 4'd2,
      PH_SET1  = 4'd3,
      PH_WCC1  = 4'd4,
      PH_W44   = 4'd5,
      PH_RST2  = 4'd6,
      PH_PRES2 = 4'd7,
      PH_SET2  = 4'd8,
      PH_WCC2  = 4'd9,
      PH_WBE   = 4'd10,
      PH_RDL   = 4'd11,
      PH_RDH   = 4'd12
   } phase_type;

   // Command byte loaded into the shift register on entry to a phase.
   function automatic logic [7:0] cmd_for_phase(input phase_type ph);
      logic [7:0] cmd;
      begin
         unique case (ph)
            PH_WCC1, PH_WCC2: cmd = CMD_SKIP_ROM;
            PH_W44:           cmd = CMD_CONVERT;
            PH_WBE:           cmd = CMD_READ_PAD;
            default:          cmd = 8'h00;
         endcase
         return cmd;
      end
   endfunction

   // Phase that follows the given one; the last read phase wraps to idle.
   function automatic phase_type next_phase(input phase_type ph);
      phase_type nxt;
      begin
         unique case (ph)
            PH_IDLE:  nxt = PH_RST1;
            PH_RST1:  nxt = PH_PRES1;
            PH_PRES1: nxt = PH_SET1;
            PH_SET1:  nxt = PH_WCC1;
            PH_WCC1:  nxt = PH_W44;
            PH_W44:   nxt = PH_RST2;
            PH_RST2:  nxt = PH_PRES2;
            PH_PRES2: nxt = PH_SET2;
            PH_SET2:  nxt = PH_WCC2;
            PH_WCC2:  nxt = PH_WBE;
            PH_WBE:   nxt = PH_RDL;
            PH_RDL:   nxt = PH_RDH;
            default:  nxt = PH_IDLE;
         endcase
         return nxt;
      end
   endfunction

endpackage

`default_nettype wire

### hdl/owtr_csr.sv
// Register file for the reader's timing settings behind an APB-style port.
`default_nettype none

module owtr_csr
   import owtr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type     cfg_ff, cfg_in;
   logic        wr_en;
   csr_idx_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = csr_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_RESET_LOW:     cfg_in.reset_low_ticks     = pwdata[11:0];
            REG_PRESENCE_POLL: cfg_in.presence_poll_ticks = pwdata[15:0];
            REG_PRESENCE_CNT:  cfg_in.presence_polls      = pwdata[3:0];
            REG_SETTLE:        cfg_in.settle_ticks        = pwdata[15:0];
            REG_WRITE_HOLD:    cfg_in.write_hold_ticks    = pwdata[7:0];
            REG_READ_SAMPLE:   cfg_in.read_sample_ticks   = pwdata[5:0];
            REG_READ_RECOVER:  cfg_in.read_recover_ticks  = pwdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_RESET_LOW:     prdata = {20'd0, cfg_ff.reset_low_ticks};
         REG_PRESENCE_POLL: prdata = {16'd0, cfg_ff.presence_poll_ticks};
         REG_PRESENCE_CNT:  prdata = {28'd0, cfg_ff.presence_polls};
         REG_SETTLE:        prdata = {16'd0, cfg_ff.settle_ticks};
         REG_WRITE_HOLD:    prdata = {24'd0, cfg_ff.write_hold_ticks};
         REG_READ_SAMPLE:   prdata = {26'd0, cfg_ff.read_sample_ticks};
         REG_READ_RECOVER:  prdata = {24'd0, cfg_ff.read_recover_ticks};
         default:           prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks     <= RESET_LOW_DEFAULT;
         cfg_ff.presence_poll_ticks <= PRESENCE_POLL_DEFAULT;
         cfg_ff.presence_polls      <= PRESENCE_CNT_DEFAULT;
         cfg_ff.settle_ticks        <= SETTLE_DEFAULT;
         cfg_ff.write_hold_ticks    <= WRITE_HOLD_DEFAULT;
         cfg_ff.read_sample_ticks   <= READ_SAMPLE_DEFAULT;
         cfg_ff.read_recover_ticks  <= READ_RECOVER_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### hdl/owtr_seq.sv
// Bus sequencer: phase, counters and shift register, advanced by one tick per beat.
`default_nettype none

module owtr_seq
   import owtr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    advance,
   input  req_type      tick,
   input  cfg_type      cfg,
   output rsp_type      result
);

   phase_type   phase_ff, phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [3:0]  poll_ff, poll_in;
   logic [2:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  low_ff, low_in;
   logic [15:0] temp_ff, temp_in;
   logic        missing_ff, missing_in;

   phase_type   ph, target;
   logic [15:0] tc;
   logic [3:0]  pc;
   logic [2:0]  bc;
   logic [7:0]  sb;
   logic        mf, enter, drive, busy, done;
   logic [16:0] tc_plus;
   logic [5:0]  sample_at;
   logic [8:0]  slot_end;
   logic [8:0]  hold_end;

   always_comb begin
      ph = phase_ff;
      tc = tick_ff;
      pc = poll_ff;
      bc = bit_ff;
      sb = shift_ff;
      mf = missing_ff;
      // A start while idle opens the reading in this very tick.
      if (ph == PH_IDLE && tick.start_req) begin
         mf = 1'b0;
         ph = PH_RST1;
         tc = 16'd0;
         pc = 4'd0;
         bc = 3'd0;
         sb = cmd_for_phase(PH_RST1);
      end

      busy       = (ph != PH_IDLE);
      drive      = 1'b0;
      done       = 1'b0;
      enter      = 1'b0;
      target     = next_phase(ph);
      tick_in    = tc;
      poll_in    = pc;
      bit_in     = bc;
      shift_in   = sb;
      low_in     = low_ff;
      temp_in    = temp_ff;
      missing_in = mf;
      tc_plus    = {1'b0, tc} + 17'd1;
      sample_at  = (cfg.read_sample_ticks == 6'd0) ? 6'd1 : cfg.read_sample_ticks;
      slot_end   = {3'd0, sample_at} + {1'b0, cfg.read_recover_ticks};
      hold_end   = {1'b0, cfg.write_hold_ticks} + 9'd1;

      unique case (ph)
         PH_IDLE: begin
         end
         PH_RST1, PH_RST2: begin
            drive = 1'b1;
            if (tc_plus >= {5'd0, cfg.reset_low_ticks}) begin
               enter = 1'b1;
            end else begin
               tick_in = tc_plus[15:0];
            end
         end
         PH_PRES1, PH_PRES2: begin
            if (tc == 16'd0 && !tick.line_level) begin
               enter = 1'b1;
            end else if (tc_plus >= {1'b0, cfg.presence_poll_ticks}) begin
               tick_in = 16'd0;
               if (pc >= cfg.presence_polls) begin
                  missing_in = 1'b1;
                  enter      = 1'b1;
               end else begin
                  poll_in = pc + 4'd1;
               end
            end else begin
               tick_in = tc_plus[15:0];
            end
         end
         PH_SET1, PH_SET2: begin
            if (tc_plus >= {1'b0, cfg.settle_ticks}) begin
               enter = 1'b1;
            end else begin
               tick_in = tc_plus[15:0];
            end
         end
         PH_WCC1, PH_W44, PH_WCC2, PH_WBE: begin
            if (tc == 16'd0) begin
               drive = 1'b1;
            end else if (tc <= {8'd0, cfg.write_hold_ticks}) begin
               drive = ~sb[0];
            end
            if (tc >= {7'd0, hold_end}) begin
               shift_in = {1'b0, sb[7:1]};
               if (bc == 3'd7) begin
                  enter = 1'b1;
               end else begin
                  bit_in  = bc + 3'd1;
                  tick_in = 16'd0;
               end
            end else begin
               tick_in = tc_plus[15:0];
            end
         end
         PH_RDL, PH_RDH: begin
            if (tc == 16'd0) begin
               drive = 1'b1;
            end
            if (tc == {10'd0, sample_at}) begin
               shift_in = {tick.line_level, sb[7:1]};
            end
            if (tc >= {7'd0, slot_end}) begin
               if (bc == 3'd7) begin
                  enter = 1'b1;
                  if (ph == PH_RDL) begin
                     low_in = shift_in;
                  end else begin
                     temp_in = {shift_in, low_ff};
                     done    = 1'b1;
                  end
               end else begin
                  bit_in  = bc + 3'd1;
                  tick_in = 16'd0;
               end
            end else begin
               tick_in = tc_plus[15:0];
            end
         end
         default: begin
            enter  = 1'b1;
            target = PH_IDLE;
         end
      endcase

      phase_in = ph;
      if (enter) begin
         phase_in = target;
         tick_in  = 16'd0;
         poll_in  = 4'd0;
         bit_in   = 3'd0;
         shift_in = cmd_for_phase(target);
      end

      result.drive_low        = drive;
      result.busy_res         = busy;
      result.done_res         = done;
      result.temperature      = temp_in;
      result.presence_missing = missing_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         tick_ff    <= 16'd0;
         poll_ff    <= 4'd0;
         bit_ff     <= 3'd0;
         shift_ff   <= 8'd0;
         low_ff     <= 8'd0;
         temp_ff    <= 16'd0;
         missing_ff <= 1'b0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         poll_ff    <= poll_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         low_ff     <= low_in;
         temp_ff    <= temp_in;
         missing_ff <= missing_in;
      end
   end

endmodule

`default_nettype wire

### hdl/onewire_temperature_reader_core.sv
// Top level of the one-wire temperature reader: register file, input register, sequencer, result register.
`default_nettype none

// Each request beat is one bus tick carrying a start request and the sampled line level;
// each tick gives exactly one response beat with the drive level and reader status. One tick
// is taken every clock cycle when the response side is not stalled: the input register
// feeds the sequencer, whose combinational next-state logic fills the result register, so
// each response passes the input and result registers in turn. Timing is set in ticks through
// the seven APB registers at byte addresses 0 to 24, to be written only while the reader is
// idle. The temperature field keeps the last word read until the next reading finishes.
module onewire_temperature_reader_core
   import owtr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   logic    advance;
   cfg_type cfg;
   rsp_type result;

   // The sequencer moves on only when the result register has room for its answer.
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign in_valid_in  = (req_valid & req_ready) | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_ready);

   owtr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   owtr_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .tick    (in_data_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

`ifndef ASSERT_OFF
   a_done_within_reading: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.done_res) |-> rsp_data.busy_res)
      else $error("done beat outside a reading");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_ready)
      else $error("input stalled with an empty result register");

   a_tick_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ready) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("pending tick lost while the response side stalled");
`endif

endmodule

`default_nettype wire
